>>> sv/vector_projection_3d_core_assert.svh
`ifndef VECTOR_PROJECTION_3D_CORE_ASSERT_SVH
`define VECTOR_PROJECTION_3D_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define VP3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define VP3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/vp3_pkg.sv
package vp3_pkg;

	localparam int FRONT_STAGES = 5;
	localparam int SQ_A_STEPS   = 32;
	localparam int DIV_STEPS    = 64;
	localparam int SQ_Q_STEPS   = 31;
	localparam int PIPE_STAGES  = FRONT_STAGES + SQ_A_STEPS + DIV_STEPS + SQ_Q_STEPS;

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAX = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
	} vec_t;

	typedef struct packed {
		logic [30:0]        dist_perp;
		logic signed [31:0] along_comp;
		logic               axis_zero;
		logic               saturated;
	} res_t;

	typedef struct packed {
		logic [127:0] sc;
		logic [63:0]  sa;
		logic [63:0]  sb;
		logic [63:0]  dmag;
		logic         dneg;
	} front_t;

endpackage

>>> sv/vector_projection_3d_core.sv
// Projection of a 3-D vector B onto the line of a reference vector A, Q16.16.
// Input channel vec/vec_valid/vec_stall carries one pair of vectors per beat;
// output channel res/res_valid/res_stall carries one result beat per input beat,
// in order. A beat moves on an edge where valid is high and stall is low.
// cfg_we/cfg_wdata write the zero length limit; write it only while idle.
// Throughput is one beat per cycle while vec_stall is low. The datapath is
// a fixed chain of 132 stages: five product and sum stages, 32 square root
// cells for |A| and |B|, 64 long division cells for A.B/|A| and
// |AxB|^2/|A|^2 side by side, then 31 square root cells for the distance.
// The output register is backed by one skid entry: while res_stall is high
// the chain keeps moving until the skid entry fills, and vec_stall is high
// exactly while the skid entry is full, at which point the whole chain holds.
// Asynchronous reset clears the valid bits, of both output entries too, and the
// limit register (limit 0); no beat is presented until one is taken.
`include "vector_projection_3d_core_assert.svh"

module vector_projection_3d_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vec_valid,
	output logic           vec_stall,
	input  vp3_pkg::vec_t  vec,
	output logic           res_valid,
	input  logic           res_stall,
	output vp3_pkg::res_t  res,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata
);

	localparam int S1 = vp3_pkg::SQ_A_STEPS;
	localparam int S2 = vp3_pkg::DIV_STEPS;
	localparam int S3 = vp3_pkg::SQ_Q_STEPS;
	localparam int NP = vp3_pkg::PIPE_STAGES;

	typedef struct packed {
		logic [127:0] sc;
		logic [63:0]  sa;
		logic [63:0]  dmag;
		logic         dneg;
		logic         dsat;
	} sb1_t;

	typedef struct packed {
		logic [31:0] blen;
		logic        zero;
		logic        dneg;
		logic        dsat;
	} sb2_t;

	typedef struct packed {
		logic [31:0] blen;
		logic        zero;
		logic        dneg;
		logic        dsat;
		logic [63:0] mag;
	} sb3_t;

	logic [15:0]     limit_q;
	logic            en;
	logic            push;
	logic [NP-1:0]   vld_q;
	vp3_pkg::front_t fr;

	logic [63:0] xa [S1];
	logic [63:0] ra [S1];
	logic [63:0] xb [S1];
	logic [63:0] rb [S1];
	sb1_t        sb1_q [S1];
	sb1_t        sb1_in;

	logic [63:0] nqd [S2];
	logic [31:0] rd [S2];
	logic [31:0] dd [S2];
	logic [63:0] nqc [S2];
	logic [63:0] rc [S2];
	logic [63:0] dc [S2];
	sb2_t        sb2_q [S2];
	sb2_t        sb2_in;
	logic [31:0] len_a;

	logic [61:0] xq [S3];
	logic [61:0] rq [S3];
	sb3_t        sb3_q [S3];
	sb3_t        sb3_in;

	sb3_t          fin;
	logic          ovf;
	logic [31:0]   mag32;
	vp3_pkg::res_t res_d;

	vp3_pkg::res_t out_q, skid_q;
	logic          out_vld_q, skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign en        = !skid_vld_q;
	assign vec_stall = skid_vld_q;
	assign push      = en && vld_q[NP-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NP-2:0], vec_valid};
		end
	end

	vp3_front u_front (
		.clk (clk),
		.en  (en),
		.vec (vec),
		.fr  (fr)
	);

	// lengths of A and B
	assign sb1_in.sc   = fr.sc;
	assign sb1_in.sa   = fr.sa;
	assign sb1_in.dmag = fr.dmag;
	assign sb1_in.dneg = fr.dneg;
	assign sb1_in.dsat = fr.sc[127:62] >= {2'b0, fr.sa};

	for (genvar i = 0; i < S1; i++) begin : g_len
		logic [63:0] xai, rai, xbi, rbi;
		sb1_t        sbi;
		if (i == 0) begin : g_first
			assign xai = fr.sa;
			assign xbi = fr.sb;
			assign rai = '0;
			assign rbi = '0;
			assign sbi = sb1_in;
		end else begin : g_next
			assign xai = xa[i-1];
			assign xbi = xb[i-1];
			assign rai = ra[i-1];
			assign rbi = rb[i-1];
			assign sbi = sb1_q[i-1];
		end
		vp3_sqrt_cell #(.W(64), .STEP(i)) u_sqa (
			.clk (clk), .en (en), .x_in (xai), .r_in (rai), .x_out (xa[i]), .r_out (ra[i])
		);
		vp3_sqrt_cell #(.W(64), .STEP(i)) u_sqb (
			.clk (clk), .en (en), .x_in (xbi), .r_in (rbi), .x_out (xb[i]), .r_out (rb[i])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sb1_q[i] <= sbi;
			end
		end
	end

	// component along A and squared distance
	assign len_a       = ra[S1-1][31:0];
	assign sb2_in.blen = rb[S1-1][31:0];
	assign sb2_in.zero = len_a <= {16'b0, limit_q};
	assign sb2_in.dneg = sb1_q[S1-1].dneg;
	assign sb2_in.dsat = sb1_q[S1-1].dsat;

	for (genvar i = 0; i < S2; i++) begin : g_div
		logic [63:0] nqdi, nqci, rci, dci;
		logic [31:0] rdi, ddi;
		sb2_t        sbi;
		if (i == 0) begin : g_first
			assign nqdi = sb1_q[S1-1].dmag;
			assign rdi  = '0;
			assign ddi  = len_a;
			assign nqci = sb1_q[S1-1].sc[63:0];
			assign rci  = sb1_q[S1-1].sc[127:64];
			assign dci  = sb1_q[S1-1].sa;
			assign sbi  = sb2_in;
		end else begin : g_next
			assign nqdi = nqd[i-1];
			assign rdi  = rd[i-1];
			assign ddi  = dd[i-1];
			assign nqci = nqc[i-1];
			assign rci  = rc[i-1];
			assign dci  = dc[i-1];
			assign sbi  = sb2_q[i-1];
		end
		vp3_div_cell #(.NW(64), .DW(32)) u_divd (
			.clk (clk), .en (en), .nq_in (nqdi), .r_in (rdi), .d_in (ddi),
			.nq_out (nqd[i]), .r_out (rd[i]), .d_out (dd[i])
		);
		vp3_div_cell #(.NW(64), .DW(64)) u_divc (
			.clk (clk), .en (en), .nq_in (nqci), .r_in (rci), .d_in (dci),
			.nq_out (nqc[i]), .r_out (rc[i]), .d_out (dc[i])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sb2_q[i] <= sbi;
			end
		end
	end

	// perpendicular distance
	assign sb3_in.blen = sb2_q[S2-1].blen;
	assign sb3_in.zero = sb2_q[S2-1].zero;
	assign sb3_in.dneg = sb2_q[S2-1].dneg;
	assign sb3_in.dsat = sb2_q[S2-1].dsat;
	assign sb3_in.mag  = nqd[S2-1];

	for (genvar i = 0; i < S3; i++) begin : g_dist
		logic [61:0] xqi, rqi;
		sb3_t        sbi;
		if (i == 0) begin : g_first
			assign xqi = nqc[S2-1][61:0];
			assign rqi = '0;
			assign sbi = sb3_in;
		end else begin : g_next
			assign xqi = xq[i-1];
			assign rqi = rq[i-1];
			assign sbi = sb3_q[i-1];
		end
		vp3_sqrt_cell #(.W(62), .STEP(i)) u_sqq (
			.clk (clk), .en (en), .x_in (xqi), .r_in (rqi), .x_out (xq[i]), .r_out (rq[i])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				sb3_q[i] <= sbi;
			end
		end
	end

	assign fin = sb3_q[S3-1];

	always_comb begin
		ovf   = 1'b0;
		mag32 = fin.mag[31:0];
		if (fin.zero) begin
			ovf                  = fin.blen[31];
			res_d.dist_perp      = '0;
			res_d.along_comp     = ovf ? vp3_pkg::POS_MAX : fin.blen;
			res_d.saturated      = ovf;
		end else begin
			res_d.dist_perp = fin.dsat ? vp3_pkg::POS_MAX[30:0] : rq[S3-1][30:0];
			if (fin.dneg) begin
				ovf              = fin.mag > {32'b0, vp3_pkg::NEG_MAX};
				mag32            = ovf ? vp3_pkg::NEG_MAX : fin.mag[31:0];
				res_d.along_comp = -mag32;
			end else begin
				ovf              = fin.mag > {32'b0, vp3_pkg::POS_MAX};
				res_d.along_comp = ovf ? vp3_pkg::POS_MAX : mag32;
			end
			res_d.saturated = ovf || fin.dsat;
		end
		res_d.axis_zero = fin.zero;
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !res_stall) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !res_stall) begin
			out_q <= skid_vld_q ? skid_q : res_d;
		end else if (push) begin
			skid_q <= res_d;
		end
	end

	assign res_valid = out_vld_q;
	assign res       = out_q;

	`VP3_ASSERT_NOW(a_skid_behind_out, skid_vld_q, out_vld_q, "skid entry full with output empty")
	`VP3_ASSERT_NEXT(a_skid_fill, out_vld_q && res_stall && !skid_vld_q && push, skid_vld_q,
		"stalled beat not caught in skid entry")
	`VP3_ASSERT_NOW(a_zero_axis_dist, res_valid && res.axis_zero, res.dist_perp == 31'd0,
		"zero length axis with nonzero distance")
	`VP3_ASSERT_NEXT(a_accept_enters, vec_valid && !vec_stall, vld_q[0],
		"accepted beat missing from first stage")

endmodule

>>> sv/vp3_sqrt_cell.sv
module vp3_sqrt_cell #(
	parameter int W    = 64,
	parameter int STEP = 0
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] x_in,
	input  logic [W-1:0] r_in,
	output logic [W-1:0] x_out,
	output logic [W-1:0] r_out
);

	localparam int SH = W - 2 - 2 * STEP;
	localparam logic [W:0] BITV = (W + 1)'(1) << SH;

	logic [W:0] trial;
	logic       ge;

	assign trial = {1'b0, r_in} + BITV;
	assign ge    = {1'b0, x_in} >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= ge ? x_in - trial[W-1:0] : x_in;
			r_out <= ge ? (r_in >> 1) + BITV[W-1:0] : r_in >> 1;
		end
	end

endmodule

>>> sv/vp3_div_cell.sv
module vp3_div_cell #(
	parameter int NW = 64,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] nq_in,
	input  logic [DW-1:0] r_in,
	input  logic [DW-1:0] d_in,
	output logic [NW-1:0] nq_out,
	output logic [DW-1:0] r_out,
	output logic [DW-1:0] d_out
);

	logic [DW:0] t;
	logic [DW:0] diff;
	logic        ge;

	assign t    = {r_in, nq_in[NW-1]};
	assign diff = t - {1'b0, d_in};
	assign ge   = t >= {1'b0, d_in};

	always_ff @(posedge clk) begin
		if (en) begin
			r_out  <= ge ? diff[DW-1:0] : t[DW-1:0];
			nq_out <= {nq_in[NW-2:0], ge};
			d_out  <= d_in;
		end
	end

endmodule

>>> sv/vp3_front.sv
module vp3_front (
	input  logic           clk,
	input  logic           en,
	input  vp3_pkg::vec_t  vec,
	output vp3_pkg::front_t fr
);

	logic signed [63:0] sqa_s1 [3];
	logic signed [63:0] sqb_s1 [3];
	logic signed [63:0] cp_s1 [3];
	logic signed [63:0] cn_s1 [3];
	logic signed [63:0] dot_s1 [3];

	logic signed [64:0] cd [3];
	logic [63:0]        cmag [3];
	logic signed [65:0] ds;

	logic [63:0]        sa_s2, sb_s2;
	logic [63:0]        cmag_s2 [3];
	logic signed [65:0] ds_s2;

	logic [63:0] hh_s3 [3];
	logic [63:0] hl_s3 [3];
	logic [63:0] ll_s3 [3];
	logic [63:0] sa_s3, sb_s3, dmag_s3;
	logic        dneg_s3;

	logic [127:0] sq_s4 [3];
	logic [63:0]  sa_s4, sb_s4, dmag_s4;
	logic         dneg_s4;

	logic [127:0] sc_s5;
	logic [63:0]  sa_s5, sb_s5, dmag_s5;
	logic         dneg_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s1[0] <= vec.ax * vec.ax;
			sqa_s1[1] <= vec.ay * vec.ay;
			sqa_s1[2] <= vec.az * vec.az;
			sqb_s1[0] <= vec.bx * vec.bx;
			sqb_s1[1] <= vec.by * vec.by;
			sqb_s1[2] <= vec.bz * vec.bz;
			cp_s1[0]  <= vec.ay * vec.bz;
			cn_s1[0]  <= vec.az * vec.by;
			cp_s1[1]  <= vec.az * vec.bx;
			cn_s1[1]  <= vec.ax * vec.bz;
			cp_s1[2]  <= vec.ax * vec.by;
			cn_s1[2]  <= vec.ay * vec.bx;
			dot_s1[0] <= vec.ax * vec.bx;
			dot_s1[1] <= vec.ay * vec.by;
			dot_s1[2] <= vec.az * vec.bz;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cd[i]   = 65'(cp_s1[i]) - 65'(cn_s1[i]);
			cmag[i] = cd[i][64] ? 64'(-cd[i]) : cd[i][63:0];
		end
		ds = 66'(dot_s1[0]) + 66'(dot_s1[1]) + 66'(dot_s1[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s2   <= $unsigned(sqa_s1[0]) + $unsigned(sqa_s1[1]) + $unsigned(sqa_s1[2]);
			sb_s2   <= $unsigned(sqb_s1[0]) + $unsigned(sqb_s1[1]) + $unsigned(sqb_s1[2]);
			cmag_s2 <= cmag;
			ds_s2   <= ds;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hh_s3[i] <= cmag_s2[i][63:32] * cmag_s2[i][63:32];
				hl_s3[i] <= cmag_s2[i][63:32] * cmag_s2[i][31:0];
				ll_s3[i] <= cmag_s2[i][31:0] * cmag_s2[i][31:0];
			end
			sa_s3   <= sa_s2;
			sb_s3   <= sb_s2;
			dneg_s3 <= ds_s2[65];
			dmag_s3 <= ds_s2[65] ? 64'(-ds_s2) : ds_s2[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= {hh_s3[i], 64'b0} + {31'b0, hl_s3[i], 33'b0} + {64'b0, ll_s3[i]};
			end
			sa_s4   <= sa_s3;
			sb_s4   <= sb_s3;
			dneg_s4 <= dneg_s3;
			dmag_s4 <= dmag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s5   <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			sa_s5   <= sa_s4;
			sb_s5   <= sb_s4;
			dneg_s5 <= dneg_s4;
			dmag_s5 <= dmag_s4;
		end
	end

	assign fr.sc   = sc_s5;
	assign fr.sa   = sa_s5;
	assign fr.sb   = sb_s5;
	assign fr.dmag = dmag_s5;
	assign fr.dneg = dneg_s5;

endmodule

>>> test/tb.sv
module tb;

	logic clk;
	logic arst_n;
	logic vec_valid;
	logic vec_stall;
	vp3_pkg::vec_t vec;
	logic res_valid;
	logic res_stall;
	vp3_pkg::res_t res;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	vp3_pkg::res_t projections_due[$];
	logic [15:0] zero_limit;
	bit quiet;
	int unsigned fails;

	vector_projection_3d_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_valid (vec_valid),
		.vec_stall (vec_stall),
		.vec       (vec),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("[vector_projection_3d_core] ERROR");
		$finish;
	end

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] bitv;
		r = 64'd0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x = x - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	function automatic vp3_pkg::res_t project(vp3_pkg::vec_t v);
		vp3_pkg::res_t o;
		longint a [3];
		longint b [3];
		logic [63:0] sa;
		logic [63:0] sb;
		logic [63:0] len;
		logic [63:0] mag;
		logic signed [127:0] cr;
		logic signed [127:0] dot;
		logic signed [127:0] p1;
		logic signed [127:0] p2;
		logic [127:0] sc;
		logic [127:0] q;
		a[0] = v.ax; a[1] = v.ay; a[2] = v.az;
		b[0] = v.bx; b[1] = v.by; b[2] = v.bz;
		o = '0;
		sa = 0;
		sb = 0;
		for (int i = 0; i < 3; i++) begin
			sa = sa + 64'(a[i] * a[i]);
			sb = sb + 64'(b[i] * b[i]);
		end
		len = root64(sa);
		if (len <= 64'(zero_limit)) begin
			o.axis_zero = 1'b1;
			mag = root64(sb);
			if (mag > 64'(vp3_pkg::POS_MAX)) begin
				mag = 64'(vp3_pkg::POS_MAX);
				o.saturated = 1'b1;
			end
			o.along_comp = mag[31:0];
		end else begin
			sc = 0;
			dot = 0;
			for (int i = 0; i < 3; i++) begin
				p1 = a[(i + 1) % 3] * b[(i + 2) % 3];
				p2 = a[(i + 2) % 3] * b[(i + 1) % 3];
				cr = p1 - p2;
				if (cr < 0)
					cr = -cr;
				sc = sc + 128'(cr) * 128'(cr);
				p1 = a[i] * b[i];
				dot = dot + p1;
			end
			q = sc / 128'(sa);
			if (q >= (128'd1 << 62)) begin
				o.dist_perp = vp3_pkg::POS_MAX[30:0];
				o.saturated = 1'b1;
			end else begin
				o.dist_perp = 31'(root64(q[63:0]));
			end
			if (dot >= 0) begin
				mag = 64'(128'(dot) / 128'(len));
				if (mag > 64'(vp3_pkg::POS_MAX)) begin
					mag = 64'(vp3_pkg::POS_MAX);
					o.saturated = 1'b1;
				end
				o.along_comp = mag[31:0];
			end else begin
				mag = 64'(128'(-dot) / 128'(len));
				if (mag > 64'(vp3_pkg::NEG_MAX)) begin
					mag = 64'(vp3_pkg::NEG_MAX);
					o.saturated = 1'b1;
				end
				o.along_comp = 32'(-mag);
			end
		end
		return o;
	endfunction

	// check each result beat against the oldest prediction
	always @(posedge clk) begin
		vp3_pkg::res_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (projections_due.size() == 0) begin
				$error("result beat with nothing expected");
				fails++;
			end else begin
				e = projections_due.pop_front();
				if (res.dist_perp !== e.dist_perp) begin
					$error("dist_perp expected %0d actual %0d", e.dist_perp, res.dist_perp);
					fails++;
				end
				if (res.along_comp !== e.along_comp) begin
					$error("along_comp expected %0d actual %0d", e.along_comp, res.along_comp);
					fails++;
				end
				if (res.axis_zero !== e.axis_zero) begin
					$error("axis_zero expected %0d actual %0d", e.axis_zero, res.axis_zero);
					fails++;
				end
				if (res.saturated !== e.saturated) begin
					$error("saturated expected %0d actual %0d", e.saturated, res.saturated);
					fails++;
				end
			end
		end
	end

	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_vec(vp3_pkg::vec_t v);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			vec_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		vec <= v;
		vec_valid <= 1'b1;
		@(posedge clk);
		while (vec_stall)
			@(posedge clk);
		projections_due.push_back(project(v));
	endtask

	task automatic wait_drained();
		vec_valid <= 1'b0;
		while (projections_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_limit(logic [15:0] v);
		wait_drained();
		repeat (vp3_pkg::PIPE_STAGES + 8) @(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		zero_limit = v;
	endtask

	function automatic logic [31:0] rand_comp(int mode);
		logic [31:0] pick [5];
		pick = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF};
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			2: return $urandom_range(0, 60000) - 30000;
			3: return $urandom_range(0, 200) - 100;
			default: return pick[$urandom_range(0, 4)];
		endcase
	endfunction

	function automatic vp3_pkg::vec_t rand_vec();
		vp3_pkg::vec_t v;
		int ma;
		int mb;
		ma = $urandom_range(0, 4);
		mb = $urandom_range(0, 4);
		v.ax = rand_comp(ma);
		v.ay = rand_comp(ma);
		v.az = rand_comp(ma);
		v.bx = rand_comp(mb);
		v.by = rand_comp(mb);
		v.bz = rand_comp(mb);
		return v;
	endfunction

	task automatic send_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
			logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
		vp3_pkg::vec_t v;
		v.ax = ax; v.ay = ay; v.az = az;
		v.bx = bx; v.by = by; v.bz = bz;
		send_vec(v);
	endtask

	task automatic test_directed();
		set_limit(16'd0);
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pair(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pair(0, 0, 0, 32'h0001_0000, 0, 0);
		send_pair(1, 0, 0, 0, 32'h8000_0000, 32'h8000_0000);
		send_pair(1, 1, 0, 32'h8000_0000, 32'h8000_0000, 0);
		send_pair(1, 1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_pair(1, 0, 0, 32'h8000_0000, 0, 0);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		send_pair(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);
		send_pair(32'h0003_0000, 32'h0004_0000, 0, 32'hFFFD_0000, 32'h0002_0000, 32'h0005_0000);
		send_pair(32'hFFFF_FFFF, 0, 0, 5, 7, 9);
		set_limit(16'hFFFF);
		send_pair(32'h0000_FFFF, 0, 0, 3, 4, 12);
		send_pair(32'h0001_0000, 0, 0, 3, 4, 12);
		send_pair(32'h0000_9000, 32'h0000_9000, 32'h0000_9000, 32'h8000_0000, 0, 0);
		send_pair(32'hFFFF_0001, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
	endtask

	task automatic test_random(int n);
		repeat (n) send_vec(rand_vec());
	endtask

	task automatic test_drain_pause();
		test_random(60);
		wait_drained();
		test_random(60);
	endtask

	task automatic test_full_rate();
		wait_drained();
		quiet = 1'b1;
		test_random(200);
	endtask

	initial begin
		arst_n = 1'b0;
		vec_valid = 1'b0;
		vec = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		zero_limit = '0;
		quiet = 1'b0;
		fails = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_limit(16'd0);
		test_random(350);
		test_drain_pause();
		set_limit(16'hFFFF);
		test_random(300);
		set_limit(16'($urandom_range(1, 65534)));
		test_random(250);
		set_limit(16'd40000);
		test_full_rate();
		vec_valid <= 1'b0;
		while (projections_due.size() != 0)
			@(posedge clk);
		repeat (vp3_pkg::PIPE_STAGES + 20) @(posedge clk);
		if (fails == 0) begin
			$display("[vector_projection_3d_core] OK");
		end else begin
			$display("[vector_projection_3d_core] ERROR");
		end
		$finish;
	end
endmodule
